[design/ohd_pkg.sv]
// Shared types, constants and helpers for the overstrike highlight decoder.
// No dependencies; imported by every module of the block.
package ohd_pkg;

    // Register map
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_ENABLE   = 0;
    localparam int REG_IDX_W    = 1;

    // Sizing
    localparam int OFFSET_BITS_DEF = 32;
    localparam int QDEPTH          = 4;
    localparam int CHAR_W          = 32;
    localparam int LEN_W           = 3;
    localparam int OUT_W           = 32;

    // Character codes (first byte)
    localparam logic [7:0] BACKSPACE  = 8'h08;
    localparam logic [7:0] UNDERSCORE = 8'h5F;

    // Input op codes
    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_SPAN = 1'b1;

    // Span kinds
    localparam logic SPAN_UNDERLINE = 1'b0;
    localparam logic SPAN_BOLD      = 1'b1;

    // One character: bytes and byte count
    typedef struct packed {
        logic [CHAR_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } slot_t;

    // Work handed from front to back: up to two characters; a command with
    // no characters left reports any open span (flush tail)
    typedef struct packed {
        logic [1:0] nch;
        logic       marked;
        logic       mtype;
        slot_t      slot0;
        slot_t      slot1;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] out_char;
        logic [LEN_W-1:0]  out_length;
        logic [OUT_W-1:0]  out_offset;
        logic [OUT_W-1:0]  span_begin;
        logic [OUT_W-1:0]  span_finish;
        logic              span_kind;
        logic              last;
    } res_t;

    // Clamp the length to 1..4 and clear bytes above it
    function automatic slot_t norm_slot(logic [CHAR_W-1:0] d, logic [LEN_W-1:0] l);
        slot_t s;
        s.data = d;
        case (l)
            3'd0, 3'd1: begin
                s.len  = 3'd1;
                s.data = {24'h0, d[7:0]};
            end
            3'd2: begin
                s.len  = 3'd2;
                s.data = {16'h0, d[15:0]};
            end
            3'd3: begin
                s.len  = 3'd3;
                s.data = {8'h0, d[23:0]};
            end
            default: begin
                s.len  = 3'd4;
                s.data = d;
            end
        endcase
        return s;
    endfunction

endpackage

[design/ohd_front.sv]
// Front end: accepts items, keeps the two-character window and classifies
// each item into a command for the back end. Depends on ohd_pkg.
module ohd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          enable,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_op,
    input  logic [31:0]   s_char_data,
    input  logic [2:0]    s_char_length,
    input  logic          q_full,
    output logic          push,
    output ohd_pkg::cmd_t cmd
);
    import ohd_pkg::*;

    slot_t      win0_reg, win0_next;
    slot_t      win1_reg, win1_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       has_work;
    slot_t      c;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign push    = accept && has_work;

    // Window update and command classification
    always_comb begin
        c          = norm_slot(s_char_data, s_char_length);
        win0_next  = win0_reg;
        win1_next  = win1_reg;
        count_next = count_reg;
        has_work   = 1'b0;
        cmd        = '0;
        cmd.slot0  = c;
        cmd.slot1  = win1_reg;
        if (s_op == OP_FLUSH) begin
            has_work   = 1'b1;
            cmd.nch    = count_reg;
            cmd.slot0  = win0_reg;
            count_next = 2'd0;
        end else if (!enable) begin
            has_work = 1'b1;
            cmd.nch  = 2'd1;
            if (count_reg != 2'd0) begin
                cmd.slot0 = win0_reg;
                if (count_reg >= 2'd2) begin
                    win0_next = win1_reg;
                    win1_next = c;
                end else begin
                    win0_next = c;
                end
            end
        end else if (count_reg < 2'd2) begin
            if (count_reg == 2'd0) begin
                win0_next = c;
            end else begin
                win1_next = c;
            end
            count_next = count_reg + 2'd1;
        end else if (win1_reg.data[7:0] == BACKSPACE) begin
            // overstrike: drop first char and backspace, keep the new one
            has_work   = 1'b1;
            cmd.nch    = 2'd1;
            count_next = 2'd0;
            if (win0_reg == c) begin
                cmd.marked = 1'b1;
                cmd.mtype  = SPAN_BOLD;
            end else if (win0_reg.data[7:0] == UNDERSCORE) begin
                cmd.marked = 1'b1;
                cmd.mtype  = SPAN_UNDERLINE;
            end
        end else begin
            has_work  = 1'b1;
            cmd.nch   = 2'd1;
            cmd.slot0 = win0_reg;
            win0_next = win1_reg;
            win1_next = c;
        end
    end

    // Window payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            win0_reg <= win0_next;
            win1_reg <= win1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

endmodule

[design/ohd_queue.sv]
// Short command queue between front and back ends.
// Depends on ohd_pkg for the command type and depth.
module ohd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ohd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output ohd_pkg::cmd_t head
);
    import ohd_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= PTR_W'((CNT_W'(wr_ptr_reg) + 1'b1) % CNT_W'(QDEPTH));
            end
            if (pop) begin
                rd_ptr_reg <= PTR_W'((CNT_W'(rd_ptr_reg) + 1'b1) % CNT_W'(QDEPTH));
            end
            count_reg <= count_next;
        end
    end

endmodule

[design/ohd_back.sv]
// Back end: runs queued commands, tracks the output offset and the open
// highlight span, and drives the result register. Depends on ohd_pkg.
module ohd_back #(
    parameter int OFFSET_BITS = ohd_pkg::OFFSET_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  ohd_pkg::cmd_t head,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output ohd_pkg::res_t res
);
    import ohd_pkg::*;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] sbeg_reg, sbeg_next;
    logic [OFFSET_BITS-1:0] sfin_reg, sfin_next;
    logic                   skind_reg, skind_next;
    logic                   sopen_reg, sopen_next;
    logic                   idx_reg, idx_next;
    logic                   valid_reg, valid_next;
    res_t                   res_reg, res_next;
    logic                   out_free;
    logic                   at_end;
    logic                   need_close;
    logic                   last_char;
    logic                   emit;
    slot_t                  cur;
    logic [OFFSET_BITS:0]   sum;
    logic [OFFSET_BITS-1:0] pos_inc;

    assign m_valid  = valid_reg;
    assign res      = res_reg;
    assign out_free = !valid_reg || m_ready;

    // Current character and saturating offset advance
    always_comb begin
        cur       = idx_reg ? head.slot1 : head.slot0;
        at_end    = ({1'b0, idx_reg} >= head.nch);
        last_char = (2'({1'b0, idx_reg}) + 2'd1 == head.nch);
        sum       = {1'b0, pos_reg} + (OFFSET_BITS + 1)'(cur.len);
        pos_inc   = sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];
        need_close = sopen_reg && (!head.marked ||
                     !(sfin_reg == pos_reg && skind_reg == head.mtype));
    end

    // Step through the command, one result per cycle while the output is free
    always_comb begin
        pos_next   = pos_reg;
        sbeg_next  = sbeg_reg;
        sfin_next  = sfin_reg;
        skind_next = skind_reg;
        sopen_next = sopen_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        emit       = 1'b0;
        pop        = 1'b0;
        if (head_valid && out_free) begin
            if (at_end) begin
                // flush tail: report the open span, if any
                pop      = 1'b1;
                idx_next = 1'b0;
                if (sopen_reg) begin
                    emit             = 1'b1;
                    sopen_next       = 1'b0;
                    res_next         = '0;
                    res_next.kind    = KIND_SPAN;
                    res_next.span_begin  = OUT_W'(sbeg_reg);
                    res_next.span_finish = OUT_W'(sfin_reg);
                    res_next.span_kind   = skind_reg;
                    res_next.last        = 1'b1;
                end
            end else if (need_close) begin
                emit                 = 1'b1;
                sopen_next           = 1'b0;
                res_next             = '0;
                res_next.kind        = KIND_SPAN;
                res_next.span_begin  = OUT_W'(sbeg_reg);
                res_next.span_finish = OUT_W'(sfin_reg);
                res_next.span_kind   = skind_reg;
            end else begin
                emit                = 1'b1;
                res_next            = '0;
                res_next.kind       = KIND_CHAR;
                res_next.out_char   = cur.data;
                res_next.out_length = cur.len;
                res_next.out_offset = OUT_W'(pos_reg);
                res_next.last       = last_char;
                pos_next            = pos_inc;
                if (head.marked) begin
                    if (!sopen_reg) begin
                        sopen_next = 1'b1;
                        sbeg_next  = pos_reg;
                        skind_next = head.mtype;
                    end
                    sfin_next = pos_inc;
                end
                if (last_char) begin
                    pop      = 1'b1;
                    idx_next = 1'b0;
                end else begin
                    idx_next = 1'b1;
                end
            end
        end
        if (emit) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            res_reg <= res_next;
        end
    end

    // Offset, span and sequencing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            sbeg_reg  <= '0;
            sfin_reg  <= '0;
            skind_reg <= 1'b0;
            sopen_reg <= 1'b0;
            idx_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            sbeg_reg  <= sbeg_next;
            sfin_reg  <= sfin_next;
            skind_reg <= skind_next;
            sopen_reg <= sopen_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[design/overstrike_highlight_decoder_core.sv]
// Overstrike highlight decoder. Takes one whole UTF-8 character per item
// (or a flush op) and returns cleaned characters with their byte offset,
// plus closed bold/underline spans. The front end accepts one item per
// cycle whenever the four-entry command queue has room; the back end emits
// one result per cycle while the output is not stalled, so an item that yields
// two or three results (span close plus character, or a flush) holds the back
// end until it has emitted them all, and a flush with nothing pending is still
// popped by the back end. A result held on m_valid does not block input until the queue fills.
// The enable register (address 0) is written over the APB-style port.
// Depends on ohd_pkg, ohd_front, ohd_queue and ohd_back.
module overstrike_highlight_decoder_core #(
    parameter int OFFSET_BITS = ohd_pkg::OFFSET_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ohd_pkg::PADDR_W-1:0] paddr,
    input  logic [ohd_pkg::PDATA_W-1:0] pwdata,
    output logic [ohd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [31:0]                 s_char_data,
    input  logic [2:0]                  s_char_length,
    // results
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_kind,
    output logic [31:0]                 m_out_char,
    output logic [2:0]                  m_out_length,
    output logic [31:0]                 m_out_offset,
    output logic [31:0]                 m_span_begin,
    output logic [31:0]                 m_span_finish,
    output logic                        m_span_kind,
    output logic                        m_last
);
    import ohd_pkg::*;

    logic                 enable_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 q_full;
    logic                 push;
    cmd_t                 push_cmd;
    logic                 pop;
    logic                 head_valid;
    cmd_t                 head;
    res_t                 res;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (psel && penable && pwrite && reg_idx == REG_IDX_W'(REG_ENABLE)) begin
            enable_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_IDX_W'(REG_ENABLE)) begin
            prdata[0] = enable_reg;
        end
    end

    ohd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .enable        (enable_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_char_data   (s_char_data),
        .s_char_length (s_char_length),
        .q_full        (q_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    ohd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    ohd_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .res        (res)
    );

    // Result ports
    assign m_kind        = res.kind;
    assign m_out_char    = res.out_char;
    assign m_out_length  = res.out_length;
    assign m_out_offset  = res.out_offset;
    assign m_span_begin  = res.span_begin;
    assign m_span_finish = res.span_finish;
    assign m_span_kind   = res.span_kind;
    assign m_last        = res.last;

endmodule

[design/ohd_checker.sv]
// Port-level checks for the overstrike highlight decoder, bound to the top.
// Depends on ohd_pkg and overstrike_highlight_decoder_core.
module ohd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [31:0] m_out_char,
    input logic [2:0]  m_out_length
);
    import ohd_pkg::*;

    // A stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Span results carry no character length
    a_span_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_SPAN |-> m_out_length == 3'd0)
        else $error("span result with nonzero length");

    // Character results carry 1..4 bytes
    a_char_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_CHAR |-> m_out_length >= 3'd1 && m_out_length <= 3'd4)
        else $error("character length out of range");

    // Bytes above a one-byte character are clear
    a_char_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_CHAR && m_out_length == 3'd1 |-> m_out_char[31:8] == 24'h0)
        else $error("stray bytes above character");

    // Nothing offered right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind overstrike_highlight_decoder_core ohd_checker u_ohd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_out_char   (m_out_char),
    .m_out_length (m_out_length)
);

[tb/sv/tb_overstrike_highlight_decoder_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for overstrike_highlight_decoder_core. It sends
// directed and random character streams and checks every result item.
// An in-bench decoder model produces the expected items. Depends on ohd_pkg
// and the core RTL.
module tb_overstrike_highlight_decoder_core;
    import ohd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [PADDR_W-1:0] ADDR_ENABLE   = PADDR_W'(REG_ENABLE * 4);
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'((REG_ENABLE + 1) * 4);

    // Clock, reset and block ports
    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_op    = OP_CHAR;
    logic [31:0]         s_char_data   = '0;
    logic [2:0]          s_char_length = 3'd1;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_kind;
    logic [31:0]         m_out_char;
    logic [2:0]          m_out_length;
    logic [31:0]         m_out_offset;
    logic [31:0]         m_span_begin;
    logic [31:0]         m_span_finish;
    logic                m_span_kind;
    logic                m_last;

    // Decoder model state
    logic        cfg_enable = 1'b0;
    slot_t       win [2];
    int          win_count  = 0;
    logic [31:0] text_pos   = '0;
    logic        span_open  = 1'b0;
    logic [31:0] span_start = '0;
    logic [31:0] span_end   = '0;
    logic        span_type  = SPAN_UNDERLINE;
    res_t        step_rows[$];
    res_t        due_results[$];

    // Run bookkeeping
    int   mismatches   = 0;
    int   cycle_count  = 0;
    int   items_sent   = 0;
    int   flushes_sent = 0;
    int   text_rows    = 0;
    int   bold_spans   = 0;
    int   uline_spans  = 0;
    int   cfg_writes   = 0;
    int   stall_left   = 0;
    logic tx_gaps_on   = 1'b1;
    logic rx_stall_on  = 1'b1;

    overstrike_highlight_decoder_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_char_data   (s_char_data),
        .s_char_length (s_char_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_char    (m_out_char),
        .m_out_length  (m_out_length),
        .m_out_offset  (m_out_offset),
        .m_span_begin  (m_span_begin),
        .m_span_finish (m_span_finish),
        .m_span_kind   (m_span_kind),
        .m_last        (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("** overstrike_highlight_decoder_core: FAILED **");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one
    function automatic int pause_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (rx_stall_on && $urandom_range(0, 99) < 25) begin
            m_ready = 1'b0;
            stall_left = pause_len() - 1;
        end else begin
            m_ready = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Decoder model
    // ---------------------------------------------------------------

    // Length 0 counts as 1, 5..7 as 4; bytes past the length are cleared
    function automatic slot_t clamp_char(input logic [31:0] d, input logic [2:0] l);
        slot_t c;
        c.data = d;
        if (l <= 3'd1) begin
            c.len  = 3'd1;
            c.data = d & 32'h0000_00FF;
        end else if (l == 3'd2) begin
            c.len  = 3'd2;
            c.data = d & 32'h0000_FFFF;
        end else if (l == 3'd3) begin
            c.len  = 3'd3;
            c.data = d & 32'h00FF_FFFF;
        end else begin
            c.len = 3'd4;
        end
        return c;
    endfunction

    function automatic logic [31:0] sat_advance(input logic [31:0] pos, input logic [2:0] n);
        logic [32:0] sum;
        sum = {1'b0, pos} + 33'(n);
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    task automatic close_open_span();
        res_t r;
        if (span_open) begin
            r             = '0;
            r.kind        = KIND_SPAN;
            r.span_begin  = span_start;
            r.span_finish = span_end;
            r.span_kind   = span_type;
            step_rows.push_back(r);
            if (span_type == SPAN_BOLD)
                bold_spans++;
            else
                uline_spans++;
            span_open = 1'b0;
        end
    endtask

    task automatic push_text_row(input slot_t c);
        res_t r;
        r            = '0;
        r.kind       = KIND_CHAR;
        r.out_char   = c.data;
        r.out_length = c.len;
        r.out_offset = text_pos;
        step_rows.push_back(r);
        text_rows++;
        text_pos = sat_advance(text_pos, c.len);
    endtask

    task automatic emit_text(input slot_t c);
        close_open_span();
        push_text_row(c);
    endtask

    // A mark extends the open span only when adjacent and of the same kind
    task automatic emit_marked(input slot_t c, input logic kind);
        if (span_open && !(span_end == text_pos && span_type == kind))
            close_open_span();
        if (!span_open) begin
            span_open  = 1'b1;
            span_start = text_pos;
            span_type  = kind;
        end
        push_text_row(c);
        span_end = text_pos;
    endtask

    // Work out the results of one accepted item and queue them
    task automatic decode_item(input logic op, input logic [31:0] d, input logic [2:0] l);
        slot_t c;
        slot_t f;
        int    tail;
        step_rows.delete();
        if (op == OP_FLUSH) begin
            for (int i = 0; i < win_count; i++)
                emit_text(win[i]);
            win_count = 0;
            close_open_span();
        end else begin
            c = clamp_char(d, l);
            if (!cfg_enable) begin
                // pass-through keeps order with anything left in the window
                if (win_count == 0) begin
                    emit_text(c);
                end else begin
                    emit_text(win[0]);
                    if (win_count >= 2) begin
                        win[0] = win[1];
                        win[1] = c;
                    end else begin
                        win[0] = c;
                    end
                end
            end else if (win_count < 2) begin
                win[win_count] = c;
                win_count++;
            end else if (win[1].data[7:0] == BACKSPACE) begin
                f = win[0];
                if (f.len == c.len && f.data == c.data)
                    emit_marked(c, SPAN_BOLD);
                else if (f.data[7:0] == UNDERSCORE)
                    emit_marked(c, SPAN_UNDERLINE);
                else
                    emit_text(c);
                win_count = 0;
            end else begin
                emit_text(win[0]);
                win[0] = win[1];
                win[1] = c;
            end
        end
        if (step_rows.size() > 0) begin
            tail = step_rows.size() - 1;
            step_rows[tail].last = 1'b1;
            foreach (step_rows[i])
                due_results.push_back(step_rows[i]);
        end
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    function automatic string row_text(input res_t r);
        return $sformatf("kind %0d char %h len %0d off %0d span %0d..%0d sk %0d last %0d",
                         r.kind, r.out_char, r.out_length, r.out_offset,
                         r.span_begin, r.span_finish, r.span_kind, r.last);
    endfunction

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_result();
        res_t got;
        res_t want;
        got.kind        = m_kind;
        got.out_char    = m_out_char;
        got.out_length  = m_out_length;
        got.out_offset  = m_out_offset;
        got.span_begin  = m_span_begin;
        got.span_finish = m_span_finish;
        got.span_kind   = m_span_kind;
        got.last        = m_last;
        if (due_results.size() == 0) begin
            log_failure({"unexpected result: ", row_text(got)});
        end else begin
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.out_char !== want.out_char ||
                got.out_length !== want.out_length || got.out_offset !== want.out_offset ||
                got.span_begin !== want.span_begin || got.span_finish !== want.span_finish ||
                got.span_kind !== want.span_kind || got.last !== want.last)
                log_failure({"result mismatch\n  expected ", row_text(want),
                             "\n  actual   ", row_text(got)});
        end
    endtask

    // Register writes, accepted items and results, all seen at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == ADDR_ENABLE)
                cfg_enable = pwdata[0];
            if (s_valid && s_ready)
                decode_item(s_op, s_char_data, s_char_length);
            if (m_valid && m_ready)
                check_result();
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        cfg_writes++;
    endtask

    task automatic reg_read_check();
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_ENABLE;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== PDATA_W'(cfg_enable))
            log_failure($sformatf("enable read back %h, expected %0d", prdata, cfg_enable));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // One input item; valid stays high into the next item when there is no gap
    task automatic send_item(input logic op, input logic [31:0] d, input logic [2:0] l);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 99) >= 55) ? pause_len() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op          = op;
        s_char_data   = d;
        s_char_length = l;
        s_valid       = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (op == OP_FLUSH)
            flushes_sent++;
    endtask

    task automatic send_char(input logic [31:0] d, input logic [2:0] l);
        send_item(OP_CHAR, d, l);
    endtask

    // Flush carries random data that the block must ignore
    task automatic send_flush();
        send_item(OP_FLUSH, $urandom(), 3'($urandom_range(0, 7)));
    endtask

    // Drop valid and let every expected item come out, then a quiet spell
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Lengths mostly 1..4, sometimes out of range
    function automatic logic [2:0] rand_len();
        logic [2:0] odd [4] = '{3'd0, 3'd5, 3'd6, 3'd7};
        if ($urandom_range(0, 19) < 16)
            return 3'($urandom_range(1, 4));
        return odd[$urandom_range(0, 3)];
    endfunction

    // Random character that is never taken for a backspace
    function automatic logic [31:0] rand_plain();
        logic [31:0] d;
        d = $urandom();
        if (d[7:0] == BACKSPACE)
            d[7:0] = 8'h61;
        return d;
    endfunction

    // first, backspace, then a character that makes bold, underline or plain
    task automatic send_overstrike();
        logic [31:0] f;
        logic [31:0] bs;
        logic [31:0] c;
        logic [31:0] noise;
        logic [2:0]  fl;
        logic [2:0]  cl;
        int          pick;
        f     = rand_plain();
        fl    = rand_len();
        bs    = $urandom();
        bs[7:0] = BACKSPACE;
        c     = $urandom();
        cl    = rand_len();
        noise = $urandom();
        pick  = $urandom_range(0, 99);
        if (pick < 40) begin
            c  = f;
            cl = fl;
            // same character after clamping, different raw upper bytes
            if (fl == 3'd1 && noise[0])
                c = {noise[31:8], f[7:0]};
            if (fl == 3'd1 && noise[1])
                cl = 3'd0;
        end else if (pick < 70) begin
            f[7:0] = UNDERSCORE;
        end
        send_char(f, fl);
        send_char(bs, rand_len());
        send_char(c, cl);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset state: characters come straight through, unmapped writes ignored
    task automatic test_passthrough();
        reg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        reg_read_check();
        send_char(32'hFFFF_FFFF, 3'd0);
        send_char(32'hDEAD_BEEF, 3'd7);
        send_char(32'h0000_0000, 3'd4);
        send_flush();
        wait_drained();
    endtask

    // Bold, underline, span merge and close, flush of window and open span
    task automatic test_overstrike_marks();
        reg_write(ADDR_ENABLE, 32'hFFFF_FFFF);
        reg_read_check();
        // bold
        send_char(32'h41, 3'd1);
        send_char(32'h08, 3'd1);
        send_char(32'h41, 3'd1);
        // adjacent bold, four bytes, length 7 clamps to 4: merges
        send_char(32'hFFFF_FFFF, 3'd4);
        send_char(32'h08, 3'd1);
        send_char(32'hFFFF_FFFF, 3'd7);
        // underline closes the bold span
        send_char(32'h5F, 3'd1);
        send_char(32'h08, 3'd1);
        send_char(32'h78, 3'd1);
        // only first bytes count for underscore and backspace; merges
        send_char(32'h0000_205F, 3'd2);
        send_char(32'h002A_0008, 3'd3);
        send_char(32'h0000_A9C3, 3'd2);
        // equal bytes, unequal lengths: plain, closes the span
        send_char(32'h0000_0041, 3'd2);
        send_char(32'h08, 3'd1);
        send_char(32'h41, 3'd1);
        // flush with a full window
        send_char(32'h7A, 3'd1);
        send_char(32'h08, 3'd1);
        send_flush();
        // flush closes a span left open
        send_char(32'h78, 3'd1);
        send_char(32'h08, 3'd1);
        send_char(32'h78, 3'd1);
        send_flush();
        wait_drained();
    endtask

    // Phases of random streams under different enable settings and pacing
    task automatic test_random_stream();
        int          target;
        int          r;
        logic [31:0] d;
        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            d    = $urandom();
            d[0] = (phase != 1);
            if (phase == 1)
                d = 32'h0;
            reg_write(ADDR_ENABLE, d);
            reg_read_check();
            tx_gaps_on  = (phase != 2);
            rx_stall_on = (phase != 2);
            target = items_sent + 50;
            while (items_sent < target) begin
                // sender holds off until the block has caught up
                if (phase == 3 && items_sent >= target - 25 && items_sent < target - 22)
                    wait_drained();
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    send_overstrike();
                end else if (r < 72) begin
                    send_char(rand_plain(), rand_len());
                end else if (r < 80) begin
                    send_flush();
                end else if (r < 90) begin
                    // broken sequence: backspace cut short by a flush
                    d = $urandom();
                    d[7:0] = BACKSPACE;
                    if (r < 85)
                        send_char(rand_plain(), rand_len());
                    send_char(d, rand_len());
                    send_flush();
                end else begin
                    send_char($urandom(), 3'($urandom_range(0, 7)));
                end
            end
            // leave characters in the window across the enable change
            send_char(rand_plain(), rand_len());
            send_char(rand_plain(), rand_len());
        end
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        send_flush();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_passthrough();
        test_overstrike_marks();
        test_random_stream();
        wait_drained();
        $display("Sent %0d items (%0d flushes) across %0d register writes;",
                 items_sent, flushes_sent, cfg_writes);
        $display("checked %0d characters, %0d bold and %0d underline spans.",
                 text_rows, bold_spans, uline_spans);
        if (mismatches == 0) begin
            $display("** overstrike_highlight_decoder_core: PASSED **");
        end else begin
            $display("%0d failures", mismatches);
            $display("** overstrike_highlight_decoder_core: FAILED **");
        end
        $finish;
    end

endmodule
